// ===== sv/qdc_pkg.sv =====
package qdc_pkg;

    localparam int BINS     = 4096;
    localparam int CHANNELS = 32;
    localparam int MODULES  = 16;
    localparam int BIN_W    = 12;
    localparam int CH_W     = 5;
    localparam int MOD_W    = 4;

    localparam logic [2:0] TYPE_HEADER = 3'd2;
    localparam logic [2:0] TYPE_DATA   = 3'd0;
    localparam logic [2:0] TYPE_END    = 3'd4;
    localparam logic [2:0] TYPE_FILLER = 3'd6;

    localparam logic [2:0] ACT_WORD     = 3'd0;
    localparam logic [2:0] ACT_CH_BIN   = 3'd1;
    localparam logic [2:0] ACT_MOD_BIN  = 3'd2;
    localparam logic [2:0] ACT_CH_CNT   = 3'd3;
    localparam logic [2:0] ACT_MOD_CNT  = 3'd4;
    localparam logic [2:0] ACT_TOTAL    = 3'd5;

    localparam logic [1:0] KIND_EVENT = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;
    localparam logic [1:0] PH_END    = 2'd2;

    localparam logic REG_CHANNEL_MODE  = 1'b0;
    localparam logic REG_RECORD_EVENTS = 1'b1;

    typedef struct packed {
        logic        start;
        logic [23:0] operand;
    } sqrt_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [11:0] root;
    } sqrt_rsp_t;

endpackage

// ===== sv/qdc_sqrt.sv =====
module qdc_sqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  qdc_pkg::sqrt_req_t req,
    output qdc_pkg::sqrt_rsp_t rsp
);

    logic [23:0] rem_reg, rem_next;
    logic [23:0] root_reg, root_next;
    logic [23:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [23:0] trial;

    assign trial = root_reg + bit_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.operand;
            root_next = '0;
            bit_next  = 24'h40_0000;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next  = rem_reg - trial;
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.root = root_reg[11:0];

endmodule

// ===== sv/qdc_event_parser_histogrammer_unit.sv =====
// Event parser and histogrammer for charge-converter readout words.
// Input channel s_axis_*: tdata = {read_bin, read_channel, first_of_block,
// data_word, action}. Output channel m_axis_*: one transaction per result,
// tlast on the final result caused by an input transaction.
// Configuration channel cfg_*: index 0 channel_mode, index 1 record_events.
// One input transaction at a time; s_axis_tready is low while it is worked.
// Header, filler and discarded words pass through the decode state alone, data
// words then through read and write states (histogram read-modify-write through
// one RAM port). Counter reads and bad words present their result out of the
// decode state, bin reads out of the read state; ready returns the cycle after
// the result is taken. An end word walks 16 channel pairs through one shared
// multiplier and a 12-step square root unit, a read-modify-write of the module
// histogram when the root is nonzero, then up to 32 event transactions, one per
// cycle while the receiver takes them. A stalled receiver holds the result
// register and the sequencer. After reset a clearing pass zeroes both histogram
// memories (one bin of each memory per cycle); no input is accepted during it,
// configuration writes are taken.
module qdc_event_parser_histogrammer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[2:0], data_word[34:3], first_of_block[35], read_channel[40:36],
    // read_bin[52:41], zero fill [55:53]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // event_number[31:0], channel[36:32], adc_value[48:37], read_value[80:49],
    // zero fill [87:81]
    output logic [87:0] m_axis_tdata,
    // kind[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic        cfg_data
);

    typedef enum logic [10:0] {
        ST_CLEAR  = 11'b000_0000_0001,
        ST_IDLE   = 11'b000_0000_0010,
        ST_DECODE = 11'b000_0000_0100,
        ST_RD     = 11'b000_0000_1000,
        ST_WR     = 11'b000_0001_0000,
        ST_MUL    = 11'b000_0010_0000,
        ST_SQRT   = 11'b000_0100_0000,
        ST_MRD    = 11'b000_1000_0000,
        ST_MWR    = 11'b001_0000_0000,
        ST_EMIT   = 11'b010_0000_0000,
        ST_OUT    = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] chist_mem [qdc_pkg::CHANNELS*qdc_pkg::BINS];
    logic [31:0] mhist_mem [qdc_pkg::MODULES*qdc_pkg::BINS];
    logic [31:0] chist_rd_reg, mhist_rd_reg;

    logic        mode_reg, record_reg;
    logic [1:0]  phase_reg;
    logic [5:0]  words_left_reg;
    logic        discard_reg;
    logic [11:0] values_reg [qdc_pkg::CHANNELS];
    logic [23:0] evcnt_reg;
    logic [7:0]  wrap_reg;
    logic [31:0] chits_reg [qdc_pkg::CHANNELS];
    logic [31:0] mhits_reg [qdc_pkg::MODULES];
    logic [31:0] total_reg;

    logic [16:0] clr_reg;
    logic [2:0]  act_reg;
    logic [31:0] word_reg;
    logic        first_reg;
    logic [4:0]  rch_reg;
    logic [11:0] rbin_reg;
    logic [4:0]  ch_reg;
    logic [3:0]  pair_reg;
    logic [11:0] root_reg;
    logic [23:0] prod_reg;
    logic [4:0]  emit_reg;
    logic        emit_sel_reg;

    logic        o_valid_reg;
    logic [1:0]  o_kind_reg;
    logic [31:0] o_evn_reg;
    logic [4:0]  o_ch_reg;
    logic [11:0] o_adc_reg;
    logic [31:0] o_rv_reg;
    logic        o_last_reg;

    qdc_pkg::sqrt_req_t sq_req;
    qdc_pkg::sqrt_rsp_t sq_rsp;

    qdc_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .rsp   (sq_rsp)
    );

    logic        in_fire, out_fire;
    logic [2:0]  wtype;
    logic [4:0]  wch;
    logic [11:0] ev_or;
    logic [4:0]  nch_m1;
    logic        hdr_ok, dat_ok, end_ok;
    logic [1:0]  ph_eff;
    logic        disc_eff;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign wtype    = word_reg[26:24];
    assign wch      = mode_reg ? {1'b0, word_reg[20:17]} : word_reg[20:16];
    assign ph_eff   = first_reg ? qdc_pkg::PH_HEADER : phase_reg;
    assign disc_eff = first_reg ? 1'b0 : discard_reg;
    assign hdr_ok   = (ph_eff == qdc_pkg::PH_HEADER) && (wtype == qdc_pkg::TYPE_HEADER);
    assign dat_ok   = (ph_eff == qdc_pkg::PH_DATA) && (wtype == qdc_pkg::TYPE_DATA);
    assign end_ok   = (ph_eff == qdc_pkg::PH_END) && (wtype == qdc_pkg::TYPE_END);
    assign nch_m1   = mode_reg ? 5'd15 : 5'd31;

    always_comb
    begin
        ev_or = '0;
        for (int i = 0; i < qdc_pkg::CHANNELS; i++)
        begin
            if (!(mode_reg && i >= 16))
            begin
                ev_or = ev_or | values_reg[i];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sq_req.start   = 1'b0;
        sq_req.operand = prod_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == 17'(qdc_pkg::CHANNELS * qdc_pkg::BINS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                priority case (act_reg)
                    qdc_pkg::ACT_WORD:
                    begin
                        if (disc_eff || wtype == qdc_pkg::TYPE_FILLER || hdr_ok)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (dat_ok)
                        begin
                            state_next = ST_RD;
                        end
                        else if (end_ok)
                        begin
                            state_next = ST_MUL;
                        end
                        else
                        begin
                            state_next = ST_OUT;
                        end
                    end
                    qdc_pkg::ACT_CH_BIN, qdc_pkg::ACT_MOD_BIN:
                    begin
                        state_next = ST_RD;
                    end
                    qdc_pkg::ACT_CH_CNT, qdc_pkg::ACT_MOD_CNT, qdc_pkg::ACT_TOTAL:
                    begin
                        state_next = ST_OUT;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_RD:
            begin
                state_next = (act_reg == qdc_pkg::ACT_WORD) ? ST_WR : ST_OUT;
            end
            ST_WR:
            begin
                state_next = ST_IDLE;
            end
            ST_MUL:
            begin
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                sq_req.start = !sq_rsp.busy && !sq_rsp.done && (root_reg == 12'd0)
                               && !emit_sel_reg;
                if (sq_rsp.done)
                begin
                    state_next = (sq_rsp.root != 12'd0) ? ST_MRD : ST_MWR;
                end
            end
            ST_MRD:
            begin
                state_next = ST_MWR;
            end
            ST_MWR:
            begin
                if (pair_reg != 4'(qdc_pkg::MODULES - 1))
                begin
                    state_next = ST_MUL;
                end
                else if (record_reg && ev_or != 12'd0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_fire && o_last_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            mode_reg       <= 1'b0;
            record_reg     <= 1'b0;
            phase_reg      <= qdc_pkg::PH_HEADER;
            words_left_reg <= '0;
            discard_reg    <= 1'b0;
            evcnt_reg      <= '0;
            wrap_reg       <= '0;
            total_reg      <= '0;
            o_valid_reg    <= 1'b0;
            pair_reg       <= '0;
            emit_reg       <= '0;
            emit_sel_reg   <= 1'b0;
            root_reg       <= '0;
            for (int i = 0; i < qdc_pkg::CHANNELS; i++)
            begin
                values_reg[i] <= '0;
                chits_reg[i]  <= '0;
            end
            for (int i = 0; i < qdc_pkg::MODULES; i++)
            begin
                mhits_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == qdc_pkg::REG_CHANNEL_MODE)
                begin
                    mode_reg <= cfg_data;
                end
                else
                begin
                    record_reg <= cfg_data;
                end
            end
            if (out_fire)
            begin
                o_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 17'd1;
                end
                ST_IDLE:
                begin
                    pair_reg     <= '0;
                    emit_reg     <= '0;
                    emit_sel_reg <= 1'b0;
                    root_reg     <= '0;
                end
                ST_DECODE:
                begin
                    if (act_reg == qdc_pkg::ACT_WORD)
                    begin
                        phase_reg   <= ph_eff;
                        discard_reg <= disc_eff;
                        if (!disc_eff)
                        begin
                            if (wtype == qdc_pkg::TYPE_FILLER)
                            begin
                                discard_reg <= 1'b1;
                            end
                            else if (hdr_ok)
                            begin
                                words_left_reg <= word_reg[13:8];
                                for (int i = 0; i < qdc_pkg::CHANNELS; i++)
                                begin
                                    values_reg[i] <= '0;
                                end
                                if (word_reg[13:8] != 6'd0)
                                begin
                                    phase_reg <= qdc_pkg::PH_DATA;
                                    total_reg <= total_reg + 32'd1;
                                end
                                else
                                begin
                                    phase_reg <= qdc_pkg::PH_END;
                                end
                            end
                            else if (dat_ok)
                            begin
                                values_reg[wch] <= word_reg[11:0];
                                chits_reg[wch]  <= chits_reg[wch] + 32'd1;
                                words_left_reg  <= words_left_reg - 6'd1;
                                if (words_left_reg == 6'd1)
                                begin
                                    phase_reg <= qdc_pkg::PH_END;
                                end
                            end
                            else if (end_ok)
                            begin
                                phase_reg      <= qdc_pkg::PH_HEADER;
                                words_left_reg <= words_left_reg - 6'd1;
                            end
                            else
                            begin
                                phase_reg   <= qdc_pkg::PH_HEADER;
                                discard_reg <= 1'b1;
                                o_valid_reg <= 1'b1;
                            end
                        end
                    end
                    else if (act_reg != 3'd6 && act_reg != 3'd7
                             && act_reg != qdc_pkg::ACT_CH_BIN
                             && act_reg != qdc_pkg::ACT_MOD_BIN)
                    begin
                        o_valid_reg <= 1'b1;
                    end
                end
                ST_RD:
                begin
                    if (act_reg != qdc_pkg::ACT_WORD)
                    begin
                        o_valid_reg <= 1'b1;
                    end
                end
                ST_SQRT:
                begin
                    if (sq_rsp.done)
                    begin
                        root_reg <= sq_rsp.root;
                    end
                end
                ST_MWR:
                begin
                    if (root_reg != 12'd0)
                    begin
                        mhits_reg[pair_reg] <= mhits_reg[pair_reg] + 32'd1;
                    end
                    root_reg <= '0;
                    pair_reg <= pair_reg + 4'd1;
                    if (pair_reg == 4'(qdc_pkg::MODULES - 1) && record_reg
                        && ev_or != 12'd0)
                    begin
                        evcnt_reg <= word_reg[23:0];
                        if (evcnt_reg[23] && !word_reg[23])
                        begin
                            wrap_reg <= wrap_reg + 8'd1;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (!o_valid_reg || out_fire)
                    begin
                        if (!emit_sel_reg || !o_last_reg)
                        begin
                            o_valid_reg  <= 1'b1;
                            emit_reg     <= emit_reg + 5'd1;
                            emit_sel_reg <= 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload capture and output data
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg   <= s_axis_tdata[2:0];
            word_reg  <= s_axis_tdata[34:3];
            first_reg <= s_axis_tdata[35];
            rch_reg   <= s_axis_tdata[40:36];
            rbin_reg  <= s_axis_tdata[52:41];
        end
        if (state_reg == ST_DECODE)
        begin
            ch_reg     <= wch;
            o_kind_reg <= qdc_pkg::KIND_READ;
            o_evn_reg  <= '0;
            o_ch_reg   <= '0;
            o_adc_reg  <= '0;
            o_last_reg <= 1'b1;
            o_rv_reg   <= '0;
            priority case (act_reg)
                qdc_pkg::ACT_WORD:    o_kind_reg <= qdc_pkg::KIND_ERROR;
                qdc_pkg::ACT_CH_CNT:  o_rv_reg <= chits_reg[rch_reg];
                qdc_pkg::ACT_MOD_CNT: o_rv_reg <= rch_reg[4] ? 32'd0 : mhits_reg[rch_reg[3:0]];
                qdc_pkg::ACT_TOTAL:   o_rv_reg <= total_reg;
                default:              o_rv_reg <= '0;
            endcase
        end
        if (state_reg == ST_RD && act_reg != qdc_pkg::ACT_WORD)
        begin
            o_rv_reg <= (act_reg == qdc_pkg::ACT_CH_BIN) ? chist_rd_reg
                      : (rch_reg[4] ? 32'd0 : mhist_rd_reg);
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= values_reg[{pair_reg, 1'b0}] * values_reg[{pair_reg, 1'b1}];
        end
        if (state_reg == ST_EMIT && (!o_valid_reg || out_fire)
            && (!emit_sel_reg || !o_last_reg))
        begin
            o_kind_reg <= qdc_pkg::KIND_EVENT;
            o_evn_reg  <= {wrap_reg, evcnt_reg};
            o_ch_reg   <= emit_reg;
            o_adc_reg  <= values_reg[emit_reg];
            o_rv_reg   <= '0;
            o_last_reg <= (emit_reg == nch_m1);
        end
    end

    // histogram memories
    logic [16:0] c_addr;
    logic [15:0] m_addr;
    logic        c_we, m_we;
    logic [31:0] c_wd, m_wd;

    always_comb
    begin
        c_we   = 1'b0;
        m_we   = 1'b0;
        c_wd   = chist_rd_reg + 32'd1;
        m_wd   = mhist_rd_reg + 32'd1;
        c_addr = (act_reg == qdc_pkg::ACT_WORD) ? {ch_reg, word_reg[11:0]}
                                                : {rch_reg, rbin_reg};
        m_addr = (state_reg == ST_MWR || state_reg == ST_MRD)
                 ? {pair_reg, root_reg} : {rch_reg[3:0], rbin_reg};
        if (state_reg == ST_WR)
        begin
            c_we = 1'b1;
        end
        if (state_reg == ST_MWR && root_reg != 12'd0)
        begin
            m_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            chist_mem[clr_reg]       <= '0;
            mhist_mem[clr_reg[15:0]] <= '0;
        end
        else
        begin
            if (c_we)
            begin
                chist_mem[c_addr] <= c_wd;
            end
            if (m_we)
            begin
                mhist_mem[m_addr] <= m_wd;
            end
        end
        chist_rd_reg <= chist_mem[c_addr];
        mhist_rd_reg <= mhist_mem[m_addr];
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tuser  = o_kind_reg;
    assign m_axis_tlast  = o_last_reg;
    assign m_axis_tdata  = {7'd0, o_rv_reg, o_adc_reg, o_ch_reg, o_evn_reg};

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input taken while a result is pending");
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("second item accepted while busy");
    a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser != 2'd3))
        else $error("bad result kind");

endmodule

// ===== bench/qdc_event_parser_histogrammer_unit_tb.sv =====
module qdc_event_parser_histogrammer_unit_tb;
    import qdc_pkg::*;

    localparam int LIMIT = 1000000;

    typedef struct {
        logic [2:0]  action;
        logic [31:0] word;
        logic        first;
        logic [4:0]  rch;
        logic [11:0] rbin;
    } qdc_item_t;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] evn;
        logic [4:0]  ch;
        logic [11:0] adc;
        logic [31:0] rv;
        logic        last;
    } qdc_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic        cfg_data = 1'b0;

    qdc_event_parser_histogrammer_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    qdc_item_t   word_queue[$];
    qdc_item_t   in_flight;
    qdc_result_t expected_results[$];
    int          src_idle = 0;
    int          snk_idle = 0;
    int          errors = 0;
    int          cycles = 0;
    int          n_items = 0;
    int          n_results = 0;

    // shadow of the block
    logic        mode_q = 1'b0;
    logic        record_q = 1'b0;
    logic [1:0]  phase_q = PH_HEADER;
    logic [5:0]  left_q = '0;
    logic        discard_q = 1'b0;
    logic [11:0] ev_val[CHANNELS];
    logic [23:0] ev_count_q = '0;
    logic [7:0]  wrap_q = '0;
    int unsigned ch_hist[CHANNELS][BINS];
    int unsigned mod_hist[MODULES][BINS];
    int unsigned ch_hits[CHANNELS];
    int unsigned mod_hits[MODULES];
    int unsigned total_q = 0;
    logic [11:0] last_val = '0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [11:0] isqrt(logic [31:0] n);
        logic [31:0] r;
        logic [31:0] b;
        r = 0;
        b = 32'd1 << 22;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r[11:0];
    endfunction

    function automatic void push_res(logic [1:0] k, logic [31:0] e, logic [4:0] c,
                                     logic [11:0] a, logic [31:0] v, logic l);
        qdc_result_t r;
        r.kind = k; r.evn = e; r.ch = c; r.adc = a; r.rv = v; r.last = l;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_word(logic [31:0] w, logic first);
        logic [2:0]  t;
        logic [4:0]  c;
        logic [11:0] m;
        logic [23:0] old;
        logic [31:0] ored;
        int          nch;
        t = w[26:24];
        if (first)
        begin
            phase_q = PH_HEADER;
            discard_q = 1'b0;
        end
        if (discard_q)
            return;
        if (t == TYPE_FILLER)
        begin
            discard_q = 1'b1;
            return;
        end
        if (phase_q == PH_HEADER && t == TYPE_HEADER)
        begin
            left_q = w[13:8];
            foreach (ev_val[i]) ev_val[i] = '0;
            if (left_q != 0)
            begin
                phase_q = PH_DATA;
                total_q++;
            end
            else
                phase_q = PH_END;
            return;
        end
        if (phase_q == PH_DATA && t == TYPE_DATA)
        begin
            c = mode_q ? {1'b0, w[20:17]} : w[20:16];
            ev_val[c] = w[11:0];
            ch_hist[c][w[11:0]]++;
            ch_hits[c]++;
            left_q = left_q - 1;
            if (left_q == 0)
                phase_q = PH_END;
            return;
        end
        if (phase_q == PH_END && t == TYPE_END)
        begin
            phase_q = PH_HEADER;
            left_q = left_q - 1;
            for (int i = 0; i < MODULES; i++)
            begin
                m = isqrt(32'(ev_val[2*i]) * 32'(ev_val[2*i+1]));
                if (m != 0)
                begin
                    mod_hist[i][m]++;
                    mod_hits[i]++;
                end
            end
            if (!record_q)
                return;
            nch = mode_q ? 16 : CHANNELS;
            ored = 0;
            for (int i = 0; i < nch; i++)
                ored |= ev_val[i];
            if (ored == 0)
                return;
            old = ev_count_q;
            ev_count_q = w[23:0];
            if (old[23] && !ev_count_q[23])
                wrap_q++;
            for (int i = 0; i < nch; i++)
                push_res(KIND_EVENT, {wrap_q, ev_count_q}, 5'(i), ev_val[i], 0,
                         i == nch - 1);
            return;
        end
        phase_q = PH_HEADER;
        discard_q = 1'b1;
        push_res(KIND_ERROR, 0, 0, 0, 0, 1'b1);
    endfunction

    function automatic void predict_item(qdc_item_t it);
        logic [31:0] v;
        v = 0;
        case (it.action)
            ACT_WORD:    begin predict_word(it.word, it.first); return; end
            ACT_CH_BIN:  v = ch_hist[it.rch][it.rbin];
            ACT_MOD_BIN: v = (it.rch < MODULES) ? mod_hist[it.rch[3:0]][it.rbin] : 0;
            ACT_CH_CNT:  v = ch_hits[it.rch];
            ACT_MOD_CNT: v = (it.rch < MODULES) ? mod_hits[it.rch[3:0]] : 0;
            ACT_TOTAL:   v = total_q;
            default:     return;
        endcase
        push_res(KIND_READ, 0, 0, 0, v, 1'b1);
    endfunction

    // input driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (s_axis_tvalid)
                begin
                    predict_item(in_flight);
                    n_items++;
                end
                if (word_queue.size() > 0 && $urandom_range(0, 99) >= src_idle)
                begin
                    in_flight = word_queue.pop_front();
                    s_axis_tdata <= {3'b000, in_flight.rbin, in_flight.rch, in_flight.first,
                                     in_flight.word, in_flight.action};
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        qdc_result_t e;
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("qdc_event_parser_histogrammer_unit_tb NOT OK");
            $finish;
        end
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                n_results++;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transaction");
                    errors++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (m_axis_tuser !== e.kind)
                    begin
                        $error("kind exp %0d got %0d", e.kind, m_axis_tuser); errors++;
                    end
                    if (m_axis_tdata[31:0] !== e.evn)
                    begin
                        $error("event_number exp %h got %h", e.evn, m_axis_tdata[31:0]);
                        errors++;
                    end
                    if (m_axis_tdata[36:32] !== e.ch)
                    begin
                        $error("channel exp %0d got %0d", e.ch, m_axis_tdata[36:32]);
                        errors++;
                    end
                    if (m_axis_tdata[48:37] !== e.adc)
                    begin
                        $error("adc_value exp %h got %h", e.adc, m_axis_tdata[48:37]);
                        errors++;
                    end
                    if (m_axis_tdata[80:49] !== e.rv)
                    begin
                        $error("read_value exp %h got %h", e.rv, m_axis_tdata[80:49]);
                        errors++;
                    end
                    if (m_axis_tlast !== e.last)
                    begin
                        $error("last exp %0d got %0d", e.last, m_axis_tlast); errors++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= snk_idle);
        end
    end

    task automatic add_item(logic [2:0] act, logic [31:0] w, logic first,
                            logic [4:0] rch, logic [11:0] rbin);
        qdc_item_t it;
        it.action = act; it.word = w; it.first = first; it.rch = rch; it.rbin = rbin;
        word_queue.push_back(it);
    endtask

    task automatic add_word(logic [2:0] t, logic [31:0] body, logic first);
        logic [31:0] w;
        w = body;
        w[26:24] = t;
        add_item(ACT_WORD, w, first, 5'($urandom), 12'($urandom));
    endtask

    task automatic add_read(logic [2:0] act, logic [4:0] rch, logic [11:0] rbin);
        add_item(act, $urandom, 1'($urandom), rch, rbin);
    endtask

    // header, n data words, end word; truncated after cut data words when cut < n
    task automatic add_event(int n, int cut, logic [23:0] evc);
        logic [31:0] w;
        w = $urandom;
        w[13:8] = 6'(n);
        add_word(TYPE_HEADER, w, 1'($urandom));
        for (int i = 0; i < n && i < cut; i++)
        begin
            w = $urandom;
            last_val = w[11:0];
            add_word(TYPE_DATA, w, 1'b0);
        end
        if (cut >= n)
        begin
            w = $urandom;
            w[23:0] = evc;
            add_word(TYPE_END, w, 1'b0);
        end
        else
            add_word(TYPE_END, $urandom, 1'b0);
    endtask

    task automatic cfg_write(logic idx, logic val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_CHANNEL_MODE)
            mode_q = val;
        else
            record_q = val;
    endtask

    task automatic drain();
        while (word_queue.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic add_random(int iters);
        int r;
        for (int k = 0; k < iters; k++)
        begin
            r = $urandom_range(0, 9);
            if (r <= 5)
                add_event(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                       : $urandom_range(0, 5),
                          64, 24'($urandom));
            else if (r == 6)
                add_read(ACT_CH_BIN, 5'($urandom), ($urandom_range(0, 1)) ? last_val
                                                                          : 12'($urandom));
            else if (r == 7)
                add_read(3'($urandom_range(2, 5)), 5'($urandom), 12'($urandom));
            else if (r == 8)
                add_item(3'($urandom), $urandom, 1'($urandom), 5'($urandom),
                         12'($urandom));
            else if ($urandom_range(0, 1))
                add_event($urandom_range(2, 5), 1, 24'($urandom));
            else
            begin
                add_word(TYPE_FILLER, $urandom, 1'b0);
                add_word(TYPE_DATA, $urandom, 1'b0);
            end
        end
    endtask

    initial
    begin
        foreach (ev_val[i]) ev_val[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        cfg_write(REG_CHANNEL_MODE, 1'b0);
        cfg_write(REG_RECORD_EVENTS, 1'b0);

        src_idle = 26;
        snk_idle = 77;
        add_read(ACT_TOTAL, 0, 0);
        add_read(ACT_CH_BIN, 5'd31, 12'hFFF);
        add_read(ACT_MOD_BIN, 5'd31, 12'h000);
        add_read(ACT_MOD_CNT, 5'd16, 0);
        add_read(3'd6, 0, 0);
        add_read(3'd7, 5'd31, 12'hFFF);
        add_word(TYPE_HEADER, 32'h0, 1'b1);
        add_word(TYPE_END, 32'hFFFF_FFFF, 1'b0);
        add_word(TYPE_HEADER, 32'h0000_0200, 1'b0);
        add_word(TYPE_DATA, 32'hF81F_FFFF, 1'b0);
        add_word(TYPE_DATA, 32'h001E_0FFF, 1'b0);
        add_word(TYPE_END, 32'h0080_0000, 1'b0);
        add_read(ACT_MOD_CNT, 5'd15, 0);
        add_read(ACT_MOD_BIN, 5'd15, 12'hFFF);
        add_read(ACT_CH_CNT, 5'd31, 0);
        add_word(TYPE_DATA, 32'h0, 1'b0);
        add_word(TYPE_HEADER, 32'h0000_0100, 1'b0);
        add_word(TYPE_FILLER, 32'h0, 1'b0);
        add_word(TYPE_HEADER, 32'h0000_0100, 1'b1);
        add_word(TYPE_DATA, 32'h0, 1'b0);
        add_word(TYPE_END, 32'h0, 1'b0);
        add_read(ACT_TOTAL, 0, 0);
        add_random(5);
        drain();

        cfg_write(REG_CHANNEL_MODE, 1'b1);
        cfg_write(REG_RECORD_EVENTS, 1'b1);
        src_idle = 77;
        snk_idle = 26;
        add_event(2, 64, 24'hFFFFFF);
        add_event(1, 64, 24'h000000);
        add_event(3, 64, 24'h800001);
        add_event(0, 64, 24'h123456);
        add_random(5);
        drain();

        cfg_write(REG_CHANNEL_MODE, 1'b0);
        src_idle = 0;
        snk_idle = 0;
        add_event(4, 64, 24'hC00000);
        add_event(2, 64, 24'h400000);
        add_random(5);
        drain();

        $display("%0d input transactions, %0d result transactions checked", n_items,
                 n_results);
        $display("covered both channel layouts, recording on and off, reads and bad words");
        if (errors == 0)
            $display("qdc_event_parser_histogrammer_unit_tb OK");
        else
            $display("qdc_event_parser_histogrammer_unit_tb NOT OK");
        $finish;
    end

endmodule
